// File: rtl/core/brs_pkg.sv
// Shared types, constants and helper functions for the Bloch rotation step block.
// Used by bloch_rotation_step; depends on nothing else.

package brs_pkg;

    // Default magnitude width of the stored vector (saturation limit, at most 32 bits).
    localparam int BRS_DATA_WIDTH = 32;

    // Fixed-point constants.
    localparam logic [31:0]        INV2PI_Q32   = 32'd683565276;   // 2^32 / (2*pi)
    localparam logic signed [33:0] CORDIC_K     = 34'sd652032874;  // CORDIC gain inverse, Q30
    localparam int                 CORDIC_STEPS = 24;
    localparam int                 DIV_STEPS    = 31;
    localparam logic signed [32:0] Q30_ONE      = 33'sd1073741824;

    // Configuration register indexes (byte address bits 4:2).
    localparam logic [2:0] REG_POS_X     = 3'd0;
    localparam logic [2:0] REG_POS_Y     = 3'd1;
    localparam logic [2:0] REG_POS_Z     = 3'd2;
    localparam logic [2:0] REG_CHEM      = 3'd3;
    localparam logic [2:0] REG_STEP_TIME = 3'd4;
    localparam logic [2:0] REG_INIT_MX   = 3'd5;
    localparam logic [2:0] REG_INIT_MY   = 3'd6;
    localparam logic [2:0] REG_INIT_MZ   = 3'd7;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_CORD = 6'b000100,
        S_SQRT = 6'b001000,
        S_DIV  = 6'b010000,
        S_HOLD = 6'b100000
    } t_state;

    // Multiplier micro-operations, in program order.
    typedef enum logic [4:0] {
        M_PH, M_BX, M_BY, M_GX, M_GY, M_GZ, M_SX, M_SY, M_SZ,
        M_ANG, M_TH, M_TL,
        M_DX, M_DY, M_DZ, M_A,
        M_CX1, M_CX2, M_CY1, M_CY2, M_CZ1, M_CZ2,
        M_RX1, M_RX2, M_RX3, M_RY1, M_RY2, M_RY3, M_RZ1, M_RZ2, M_RZ3
    } t_mop;

    // Arctangent of 2^-i in Q32 turns.
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] res;
        begin
            unique case (idx)
                5'd0:  res = 32'd536870912;
                5'd1:  res = 32'd316933406;
                5'd2:  res = 32'd167458907;
                5'd3:  res = 32'd85004756;
                5'd4:  res = 32'd42667331;
                5'd5:  res = 32'd21354465;
                5'd6:  res = 32'd10679838;
                5'd7:  res = 32'd5340245;
                5'd8:  res = 32'd2670163;
                5'd9:  res = 32'd1335087;
                5'd10: res = 32'd667544;
                5'd11: res = 32'd333772;
                5'd12: res = 32'd166886;
                5'd13: res = 32'd83443;
                5'd14: res = 32'd41722;
                5'd15: res = 32'd20861;
                5'd16: res = 32'd10430;
                5'd17: res = 32'd5215;
                5'd18: res = 32'd2608;
                5'd19: res = 32'd1304;
                5'd20: res = 32'd652;
                5'd21: res = 32'd326;
                5'd22: res = 32'd163;
                5'd23: res = 32'd81;
                default: res = 32'd0;
            endcase
            return res;
        end
    endfunction

    // Round half up, then arithmetic shift right.
    function automatic logic signed [69:0] rnd_sh(input logic signed [69:0] v,
                                                  input int unsigned sh);
        begin
            return (v + (70'sd1 <<< (sh - 1))) >>> sh;
        end
    endfunction

    // Saturate to 32-bit signed.
    function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
        logic signed [31:0] res;
        begin
            if (v > 70'sd2147483647) begin
                res = 32'sh7FFF_FFFF;
            end else if (v < -70'sd2147483648) begin
                res = 32'sh8000_0000;
            end else begin
                res = 32'(v);
            end
            return res;
        end
    endfunction

endpackage

// File: rtl/core/bloch_rotation_step.sv
// Bloch rotation step: rotates a stored magnetization vector about the RF/gradient field.
// Depends on brs_pkg for types, constants and rounding helpers.

// Channel    Direction  Handshake                  Payload
// input      in         i_in_valid / o_in_stall    rf_amp, rf_phase, grad_x/y/z, first, last
// output     out        o_out_valid / i_out_stall  mag_x/y/z, last_out
// config     in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
// An item is taken only while the block is idle; the input stalls from the accepting edge until the
// result is registered, and the next input beat can be taken in the cycle after that.
// The work per item is made up of the 32-step square root, three 31-step restoring divisions, two
// CORDIC passes and 31 operations of the single shared multiplier.
// Reset is synchronous and active low; it clears control state, the stored vector and the
// configuration registers (init_mz resets to 1.0). A stalled result holds in the output
// register; the block finishes its work and then waits until that register is free.

module bloch_rotation_step
    import brs_pkg::*;
#(
    parameter int DATA_WIDTH = BRS_DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_rf_amp,
    input  logic signed [18:0] i_rf_phase,
    input  logic signed [31:0] i_grad_x,
    input  logic signed [31:0] i_grad_y,
    input  logic signed [31:0] i_grad_z,
    input  logic               i_first,
    input  logic               i_last,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_mag_x,
    output logic signed [31:0] o_mag_y,
    output logic signed [31:0] o_mag_z,
    output logic               o_last_out,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // The stored vector saturates to at most 32 bits.
    localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam logic signed [69:0] OUT_HI = (70'sd1 <<< (SAT_W - 1)) - 70'sd1;
    localparam logic signed [69:0] OUT_LO = -(70'sd1 <<< (SAT_W - 1));

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    t_state r_state;
    t_mop   r_op;
    logic   r_cons;        // multiplier sub-phase: 0 issue, 1 consume the product
    logic   r_cinit;       // first cycle of a CORDIC pass loads the start vector
    logic   r_crot;        // CORDIC pass is for the rotation angle (else for the RF phase)
    logic [4:0] r_ci;      // CORDIC step, counts up to CORDIC_STEPS
    logic   r_dinit;       // first cycle of a division loads the operands
    logic [1:0] r_dk;      // axis component being divided
    logic [4:0] r_dcnt;    // division step
    logic   r_out_valid;

    // Configuration registers.
    logic signed [31:0] r_pos_x, r_pos_y, r_pos_z, r_chem;
    logic [30:0]        r_step;
    logic signed [31:0] r_init_mx, r_init_my, r_init_mz;

    // Stored magnetization.
    logic signed [31:0] r_vx, r_vy, r_vz;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic signed [31:0] r_amp, r_gx, r_gy, r_gz;
    logic signed [18:0] r_ph;
    logic               r_last;

    logic signed [69:0] r_prod;
    logic signed [69:0] r_acc;
    logic [31:0]        r_turn;

    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_cflip;
    logic signed [31:0] r_pc, r_ps, r_ct, r_st;

    logic signed [31:0] r_bx, r_by, r_bz;
    logic [63:0]        r_sq;
    logic [63:0]        r_sx, r_sr, r_sbit;
    logic [31:0]        r_norm;

    logic [61:0]        r_rem, r_dsh;
    logic [30:0]        r_q;
    logic               r_dneg;
    logic signed [31:0] r_nx, r_ny, r_nz;

    logic [62:0]        r_ang;
    logic signed [33:0] r_dot;
    logic signed [34:0] r_a;
    logic signed [34:0] r_crx, r_cry, r_crz;

    logic signed [31:0] r_omx, r_omy, r_omz;
    logic               r_olast;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    logic in_acc;
    logic out_load;
    logic cfg_wr;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_load   = (r_state == S_HOLD) && (!r_out_valid || !i_out_stall);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;

    assign o_out_valid = r_out_valid;
    assign o_mag_x     = r_omx;
    assign o_mag_y     = r_omy;
    assign o_mag_z     = r_omz;
    assign o_last_out  = r_olast;

    always_comb begin
        unique case (paddr[4:2])
            REG_POS_X:     prdata = r_pos_x;
            REG_POS_Y:     prdata = r_pos_y;
            REG_POS_Z:     prdata = r_pos_z;
            REG_CHEM:      prdata = r_chem;
            REG_STEP_TIME: prdata = {1'b0, r_step};
            REG_INIT_MX:   prdata = r_init_mx;
            REG_INIT_MY:   prdata = r_init_my;
            REG_INIT_MZ:   prdata = r_init_mz;
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Shared multiplier: operands are chosen by the current micro-operation,
    // and the product is registered before it is used.
    // ------------------------------------------------------------------
    logic signed [34:0] mul_a, mul_b;
    logic signed [69:0] mul_p;
    logic signed [32:0] omc;
    logic signed [69:0] rp16, rp30;
    logic signed [69:0] fin_sum, fin_sat;

    assign omc = Q30_ONE - 33'(r_ct);

    always_comb begin
        unique case (r_op)
            M_PH:  begin mul_a = 35'(r_ph);  mul_b = $signed(35'(INV2PI_Q32)); end
            M_BX:  begin mul_a = 35'(r_amp); mul_b = 35'(r_pc); end
            M_BY:  begin mul_a = 35'(r_amp); mul_b = 35'(r_ps); end
            M_GX:  begin mul_a = 35'(r_gx);  mul_b = 35'(r_pos_x); end
            M_GY:  begin mul_a = 35'(r_gy);  mul_b = 35'(r_pos_y); end
            M_GZ:  begin mul_a = 35'(r_gz);  mul_b = 35'(r_pos_z); end
            M_SX:  begin mul_a = 35'(r_bx);  mul_b = 35'(r_bx); end
            M_SY:  begin mul_a = 35'(r_by);  mul_b = 35'(r_by); end
            M_SZ:  begin mul_a = 35'(r_bz);  mul_b = 35'(r_bz); end
            M_ANG: begin
                mul_a = $signed(35'({1'b0, r_norm}));
                mul_b = $signed(35'({1'b0, r_step}));
            end
            M_TH:  begin
                mul_a = $signed(35'({1'b0, r_ang[62:32]}));
                mul_b = $signed(35'(INV2PI_Q32));
            end
            M_TL:  begin
                mul_a = $signed(35'({1'b0, r_ang[31:0]}));
                mul_b = $signed(35'(INV2PI_Q32));
            end
            M_DX:  begin mul_a = 35'(r_nx);  mul_b = 35'(r_vx); end
            M_DY:  begin mul_a = 35'(r_ny);  mul_b = 35'(r_vy); end
            M_DZ:  begin mul_a = 35'(r_nz);  mul_b = 35'(r_vz); end
            M_A:   begin mul_a = 35'(r_dot); mul_b = 35'(omc); end
            M_CX1: begin mul_a = 35'(r_ny);  mul_b = 35'(r_vz); end
            M_CX2: begin mul_a = 35'(r_nz);  mul_b = 35'(r_vy); end
            M_CY1: begin mul_a = 35'(r_nz);  mul_b = 35'(r_vx); end
            M_CY2: begin mul_a = 35'(r_nx);  mul_b = 35'(r_vz); end
            M_CZ1: begin mul_a = 35'(r_nx);  mul_b = 35'(r_vy); end
            M_CZ2: begin mul_a = 35'(r_ny);  mul_b = 35'(r_vx); end
            M_RX1: begin mul_a = 35'(r_vx);  mul_b = 35'(r_ct); end
            M_RX2: begin mul_a = r_crx;      mul_b = 35'(r_st); end
            M_RX3: begin mul_a = r_a;        mul_b = 35'(r_nx); end
            M_RY1: begin mul_a = 35'(r_vy);  mul_b = 35'(r_ct); end
            M_RY2: begin mul_a = r_cry;      mul_b = 35'(r_st); end
            M_RY3: begin mul_a = r_a;        mul_b = 35'(r_ny); end
            M_RZ1: begin mul_a = 35'(r_vz);  mul_b = 35'(r_ct); end
            M_RZ2: begin mul_a = r_crz;      mul_b = 35'(r_st); end
            M_RZ3: begin mul_a = r_a;        mul_b = 35'(r_nz); end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign rp16  = rnd_sh(r_prod, 16);
    assign rp30  = rnd_sh(r_prod, 30);

    // Last term of each rotated component, then saturation of the sum.
    assign fin_sum = r_acc + rp30;
    assign fin_sat = (fin_sum > OUT_HI) ? OUT_HI : ((fin_sum < OUT_LO) ? OUT_LO : fin_sum);

    // ------------------------------------------------------------------
    // CORDIC: one micro-rotation per cycle on a shared add/shift unit.
    // The turn is folded into plus or minus a quarter turn first.
    // ------------------------------------------------------------------
    logic               cord_flip;
    logic [31:0]        cord_pf;
    logic signed [33:0] cord_sx, cord_sy, cord_at;
    logic signed [33:0] cord_nx, cord_ny, cord_nz;
    logic signed [33:0] cord_fx, cord_fy;
    logic signed [31:0] cord_cos, cord_sin;

    assign cord_flip = (r_turn + 32'h4000_0000) >> 31 != 32'd0;
    assign cord_pf   = cord_flip ? (r_turn - 32'h8000_0000) : r_turn;
    assign cord_sx   = r_cx >>> r_ci;
    assign cord_sy   = r_cy >>> r_ci;
    assign cord_at   = $signed({2'b00, atan_turn(r_ci)});

    always_comb begin
        if (!r_cz[33]) begin
            cord_nx = r_cx - cord_sy;
            cord_ny = r_cy + cord_sx;
            cord_nz = r_cz - cord_at;
        end else begin
            cord_nx = r_cx + cord_sy;
            cord_ny = r_cy - cord_sx;
            cord_nz = r_cz + cord_at;
        end
    end

    assign cord_fx = r_cflip ? -r_cx : r_cx;
    assign cord_fy = r_cflip ? -r_cy : r_cy;

    always_comb begin
        if (cord_fx > 34'sd1073741824) begin
            cord_cos = 32'sd1073741824;
        end else if (cord_fx < -34'sd1073741824) begin
            cord_cos = -32'sd1073741824;
        end else begin
            cord_cos = 32'(cord_fx);
        end
        if (cord_fy > 34'sd1073741824) begin
            cord_sin = 32'sd1073741824;
        end else if (cord_fy < -34'sd1073741824) begin
            cord_sin = -32'sd1073741824;
        end else begin
            cord_sin = 32'(cord_fy);
        end
    end

    // ------------------------------------------------------------------
    // Integer square root, two radicand bits per cycle.
    // ------------------------------------------------------------------
    logic [63:0] sq_t;
    logic        sq_ge;
    logic [63:0] sq_nsr;

    assign sq_t   = r_sr + r_sbit;
    assign sq_ge  = (r_sx >= sq_t);
    assign sq_nsr = sq_ge ? ((r_sr >> 1) + r_sbit) : (r_sr >> 1);

    // ------------------------------------------------------------------
    // Restoring division of |B| * 2^30 by the norm, one quotient bit per cycle.
    // ------------------------------------------------------------------
    logic signed [31:0] div_b;
    logic [31:0]        div_mag;
    logic [31:0]        div_norm1;
    logic               dv_ge;
    logic [30:0]        dv_q;
    logic signed [31:0] quot;

    always_comb begin
        unique case (r_dk)
            2'd0:    div_b = r_bx;
            2'd1:    div_b = r_by;
            default: div_b = r_bz;
        endcase
    end

    assign div_mag   = div_b[31] ? (~div_b + 32'd1) : div_b;
    assign div_norm1 = (r_norm == 32'd0) ? 32'd1 : r_norm;   // a zero field gives a zero axis
    assign dv_ge     = (r_rem >= r_dsh);
    assign dv_q      = {r_q[29:0], dv_ge};
    assign quot      = r_dneg ? -$signed({1'b0, dv_q}) : $signed({1'b0, dv_q});

    // ------------------------------------------------------------------
    // Control, configuration and stored vector
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= M_PH;
            r_cons      <= 1'b0;
            r_cinit     <= 1'b0;
            r_crot      <= 1'b0;
            r_ci        <= '0;
            r_dinit     <= 1'b0;
            r_dk        <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_pos_z     <= '0;
            r_chem      <= '0;
            r_step      <= '0;
            r_init_mx   <= '0;
            r_init_my   <= '0;
            r_init_mz   <= 32'sd65536;
            r_vx        <= '0;
            r_vy        <= '0;
            r_vz        <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    REG_POS_X:     r_pos_x   <= pwdata;
                    REG_POS_Y:     r_pos_y   <= pwdata;
                    REG_POS_Z:     r_pos_z   <= pwdata;
                    REG_CHEM:      r_chem    <= pwdata;
                    REG_STEP_TIME: r_step    <= pwdata[30:0];
                    REG_INIT_MX:   r_init_mx <= pwdata;
                    REG_INIT_MY:   r_init_my <= pwdata;
                    REG_INIT_MZ:   r_init_mz <= pwdata;
                    default:       r_step    <= r_step;
                endcase
            end

            // A new result may replace one that leaves in the same cycle.
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_first) begin
                            r_vx <= r_init_mx;
                            r_vy <= r_init_my;
                            r_vz <= r_init_mz;
                        end
                        r_state <= S_MUL;
                        r_op    <= M_PH;
                        r_cons  <= 1'b0;
                    end
                end
                S_MUL: begin
                    if (!r_cons) begin
                        r_cons <= 1'b1;
                    end else begin
                        r_cons <= 1'b0;
                        unique case (r_op)
                            M_PH: begin
                                r_state <= S_CORD;
                                r_cinit <= 1'b1;
                                r_crot  <= 1'b0;
                                r_op    <= M_BX;
                            end
                            M_SZ: begin
                                r_state <= S_SQRT;
                                r_op    <= M_ANG;
                            end
                            M_TL: begin
                                r_state <= S_CORD;
                                r_cinit <= 1'b1;
                                r_crot  <= 1'b1;
                                r_op    <= M_DX;
                            end
                            M_RX3: begin
                                r_vx <= 32'(fin_sat);
                                r_op <= M_RY1;
                            end
                            M_RY3: begin
                                r_vy <= 32'(fin_sat);
                                r_op <= M_RZ1;
                            end
                            M_RZ3: begin
                                r_vz    <= 32'(fin_sat);
                                r_state <= S_HOLD;
                                r_op    <= M_PH;
                            end
                            default: begin
                                r_op <= t_mop'(5'(r_op + 5'd1));
                            end
                        endcase
                    end
                end
                S_CORD: begin
                    if (r_cinit) begin
                        r_cinit <= 1'b0;
                        r_ci    <= '0;
                    end else if (r_ci == 5'(CORDIC_STEPS)) begin
                        r_state <= S_MUL;
                    end else begin
                        r_ci <= r_ci + 5'd1;
                    end
                end
                S_SQRT: begin
                    if (r_sbit == 64'd1) begin
                        r_state <= S_DIV;
                        r_dinit <= 1'b1;
                        r_dk    <= 2'd0;
                    end
                end
                S_DIV: begin
                    if (r_dinit) begin
                        r_dinit <= 1'b0;
                        r_dcnt  <= '0;
                    end else if (r_dcnt == 5'(DIV_STEPS - 1)) begin
                        if (r_dk == 2'd2) begin
                            r_state <= S_MUL;
                        end else begin
                            r_dk    <= r_dk + 2'd1;
                            r_dinit <= 1'b1;
                        end
                    end else begin
                        r_dcnt <= r_dcnt + 5'd1;
                    end
                end
                S_HOLD: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_amp  <= i_rf_amp;
            r_ph   <= i_rf_phase;
            r_gx   <= i_grad_x;
            r_gy   <= i_grad_y;
            r_gz   <= i_grad_z;
            r_last <= i_last;
        end

        if (r_state == S_MUL) begin
            if (!r_cons) begin
                r_prod <= mul_p;
            end else begin
                unique case (r_op)
                    M_PH:  r_turn <= 32'(rp16);
                    M_BX:  r_bx   <= sat32(rnd_sh(r_prod, 30));
                    M_BY:  r_by   <= sat32(rnd_sh(r_prod, 30));
                    M_GX:  r_acc  <= 70'(r_chem) + rp16;
                    M_GY:  r_acc  <= r_acc + rp16;
                    M_GZ:  r_bz   <= sat32(r_acc + rp16);
                    M_SX:  r_sq   <= r_prod[63:0];
                    M_SY:  r_sq   <= r_sq + r_prod[63:0];
                    M_SZ: begin
                        r_sx   <= r_sq + r_prod[63:0];
                        r_sr   <= '0;
                        r_sbit <= 64'd1 << 62;
                    end
                    M_ANG: r_ang  <= r_prod[62:0];
                    M_TH:  r_acc  <= r_prod;
                    M_TL:  r_turn <= 32'(r_acc + (r_prod >>> 32));
                    M_DX:  r_acc  <= r_prod;
                    M_DY:  r_acc  <= r_acc + r_prod;
                    M_DZ:  r_dot  <= 34'(rnd_sh(r_acc + r_prod, 30));
                    M_A:   r_a    <= 35'(rp30);
                    M_CX1: r_acc  <= r_prod;
                    M_CX2: r_crx  <= 35'(rnd_sh(r_acc - r_prod, 30));
                    M_CY1: r_acc  <= r_prod;
                    M_CY2: r_cry  <= 35'(rnd_sh(r_acc - r_prod, 30));
                    M_CZ1: r_acc  <= r_prod;
                    M_CZ2: r_crz  <= 35'(rnd_sh(r_acc - r_prod, 30));
                    M_RX1: r_acc  <= rp30;
                    M_RX2: r_acc  <= r_acc + rp30;
                    M_RY1: r_acc  <= rp30;
                    M_RY2: r_acc  <= r_acc + rp30;
                    M_RZ1: r_acc  <= rp30;
                    M_RZ2: r_acc  <= r_acc + rp30;
                    default: r_acc <= r_acc;
                endcase
            end
        end

        if (r_state == S_CORD) begin
            if (r_cinit) begin
                r_cflip <= cord_flip;
                r_cx    <= CORDIC_K;
                r_cy    <= '0;
                r_cz    <= 34'($signed(cord_pf));
            end else if (r_ci == 5'(CORDIC_STEPS)) begin
                if (r_crot) begin
                    r_ct <= cord_cos;
                    r_st <= cord_sin;
                end else begin
                    r_pc <= cord_cos;
                    r_ps <= cord_sin;
                end
            end else begin
                r_cx <= cord_nx;
                r_cy <= cord_ny;
                r_cz <= cord_nz;
            end
        end

        if (r_state == S_SQRT) begin
            if (sq_ge) begin
                r_sx <= r_sx - sq_t;
            end
            r_sr   <= sq_nsr;
            r_sbit <= r_sbit >> 2;
            if (r_sbit == 64'd1) begin
                r_norm <= sq_nsr[31:0];
            end
        end

        if (r_state == S_DIV) begin
            if (r_dinit) begin
                r_rem  <= {div_mag, 30'd0};
                r_dsh  <= {div_norm1, 30'd0};
                r_q    <= '0;
                r_dneg <= div_b[31];
            end else begin
                if (dv_ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh <= r_dsh >> 1;
                r_q   <= dv_q;
                if (r_dcnt == 5'(DIV_STEPS - 1)) begin
                    unique case (r_dk)
                        2'd0:    r_nx <= quot;
                        2'd1:    r_ny <= quot;
                        default: r_nz <= quot;
                    endcase
                end
            end
        end

        if (out_load) begin
            r_omx   <= r_vx;
            r_omy   <= r_vy;
            r_omz   <= r_vz;
            r_olast <= r_last;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_MUL))
        else $error("accepted beat did not start the multiplier program");

    a_omc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_op == M_A) |->
        (omc >= 33'sd0 && omc <= 33'sd2147483648))
        else $error("one minus cosine out of range");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_op == M_DX) |->
        (r_nx <= 32'sd1073741824 && r_nx >= -32'sd1073741824 &&
         r_ny <= 32'sd1073741824 && r_ny >= -32'sd1073741824 &&
         r_nz <= 32'sd1073741824 && r_nz >= -32'sd1073741824))
        else $error("rotation axis component exceeds one");

    a_result_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HOLD))
        else $error("result beat raised outside the hold state");

endmodule
